@@ hdl/svoice_pkg.sv @@
// Shared types and constants for the synthesizer voice allocator.
`default_nettype none
package svoice_pkg;

	localparam int VOICE_COUNT = 8;
	localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int IDLE_BITS   = 8;
	localparam int STAMP_W     = 32;

	typedef logic [VIDX_W-1:0]  vidx_t;
	typedef logic [STAMP_W-1:0] stamp_t;

	localparam logic KIND_ON  = 1'b0;
	localparam logic KIND_OFF = 1'b1;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [1:0] SRC_SAME      = 2'd0;
	localparam logic [1:0] SRC_FREE_IDLE = 2'd1;
	localparam logic [1:0] SRC_FREE_BUSY = 2'd2;
	localparam logic [1:0] SRC_STOLEN    = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [6:0] note_number;
		logic [6:0] strike_velocity;
		logic [7:0] idle_mask;
	} req_t;

	typedef struct packed {
		logic [2:0] voice_slot;
		logic       action;
		logic [1:0] choice_source;
		logic [6:0] note_out;
		logic [6:0] velocity_out;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic last;
	} stat_t;

endpackage
`default_nettype wire

@@ hdl/synth_voice_allocator.sv @@
// Voice allocator top: controller and datapath that assign one note event at a time to a voice.
// The scan walks the voice tables one voice per cycle, then enters the commit state.
// busy is high through scan and commit; a new event is taken only once back in idle.
// done pulses for one cycle with the result; note-off of an unheld note gives none.
// Reset (arst_n low) frees all voices and clears stamps and the trigger counter.
`default_nettype none
module synth_voice_allocator (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  svoice_pkg::req_t    request,
	output logic                busy,
	output logic                done,
	output svoice_pkg::res_t    result
);

	svoice_pkg::cmd_t  cmd;
	svoice_pkg::stat_t stat;

	svoice_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	svoice_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule
`default_nettype wire

@@ hdl/svoice_ctrl.sv @@
// Controller state machine: load, scan over the voices, commit.
`default_nettype none
module svoice_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  svoice_pkg::stat_t   stat,
	output logic                busy,
	output svoice_pkg::cmd_t    cmd
);

	svoice_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svoice_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			svoice_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = svoice_pkg::ST_SCAN;
				end
			end
			svoice_pkg::ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = svoice_pkg::ST_COMMIT;
				end
			end
			svoice_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = svoice_pkg::ST_IDLE;
			end
			default: begin
				state_d = svoice_pkg::ST_IDLE;
			end
		endcase
	end

	a_scan_to_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svoice_pkg::ST_SCAN && stat.last) |=> state_q == svoice_pkg::ST_COMMIT)
		else $error("scan end did not lead to commit");

	a_commit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == svoice_pkg::ST_IDLE && !busy))
		else $error("commit did not return to idle");

	a_start_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == svoice_pkg::ST_SCAN && cmd.step))
		else $error("accepted event did not start a scan");

endmodule
`default_nettype wire

@@ hdl/svoice_dp.sv @@
// Datapath: voice tables, scan accumulators, commit and result register.
`default_nettype none
module svoice_dp (
	input  wire                 clk,
	input  wire                 arst_n,
	input  svoice_pkg::req_t    request,
	input  svoice_pkg::cmd_t    cmd,
	output svoice_pkg::stat_t   stat,
	output logic                done,
	output svoice_pkg::res_t    result
);

	// voice tables
	logic                   free_q  [svoice_pkg::VOICE_COUNT];
	logic [6:0]             note_q  [svoice_pkg::VOICE_COUNT];
	svoice_pkg::stamp_t     stamp_q [svoice_pkg::VOICE_COUNT];
	svoice_pkg::stamp_t     cnt_q;

	svoice_pkg::req_t       req_q;
	svoice_pkg::vidx_t      idx_q;

	// scan accumulators
	logic                   found_q;
	svoice_pkg::vidx_t      match_idx_q;
	logic                   free_any_q;
	logic                   free_idle_q;
	svoice_pkg::vidx_t      free_idx_q;
	svoice_pkg::stamp_t     best_age_q;
	svoice_pkg::vidx_t      best_idx_q;

	logic                   done_q;
	svoice_pkg::res_t       res_q;

	logic [5:0]             idx_ext;
	logic                   cur_idle;
	logic                   cur_free;
	svoice_pkg::stamp_t     cur_age;
	svoice_pkg::vidx_t      pick;
	logic [1:0]             src;
	logic                   is_off;
	logic                   emit;
	svoice_pkg::stamp_t     cnt_next;

	assign stat.last = (idx_q == svoice_pkg::VIDX_W'(svoice_pkg::VOICE_COUNT - 1));
	assign done      = done_q;
	assign result    = res_q;

	// voices past the idle mask count as busy
	assign idx_ext  = 6'(idx_q);
	assign cur_idle = (idx_ext < 6'(svoice_pkg::IDLE_BITS)) && req_q.idle_mask[idx_ext[2:0]];
	assign cur_free = free_q[idx_q];
	assign cur_age  = cnt_q - stamp_q[idx_q];
	assign cnt_next = cnt_q + svoice_pkg::STAMP_W'(1);

	always_comb begin
		pick = match_idx_q;
		src  = svoice_pkg::SRC_SAME;
		if (!found_q) begin
			if (free_any_q) begin
				pick = free_idx_q;
				src  = free_idle_q ? svoice_pkg::SRC_FREE_IDLE : svoice_pkg::SRC_FREE_BUSY;
			end else begin
				pick = best_idx_q;
				src  = svoice_pkg::SRC_STOLEN;
			end
		end
	end

	assign is_off = (req_q.kind == svoice_pkg::KIND_OFF);
	assign emit   = !is_off || found_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.step) begin
			if (!found_q && !cur_free && note_q[idx_q] == req_q.note_number) begin
				match_idx_q <= idx_q;
			end
			if (cur_free && (!free_any_q || (cur_idle && !free_idle_q))) begin
				free_idx_q  <= idx_q;
				free_idle_q <= cur_idle;
			end
			// strictly larger age wins, so ties keep the lower voice
			if (idx_q == '0 || cur_age > best_age_q) begin
				best_age_q <= cur_age;
				best_idx_q <= idx_q;
			end
		end
		if (cmd.commit) begin
			res_q.voice_slot    <= 3'(pick);
			res_q.note_out      <= req_q.note_number;
			if (is_off) begin
				res_q.action        <= svoice_pkg::ACT_RELEASE;
				res_q.choice_source <= svoice_pkg::SRC_SAME;
				res_q.velocity_out  <= '0;
			end else begin
				res_q.action        <= svoice_pkg::ACT_START;
				res_q.choice_source <= src;
				res_q.velocity_out  <= req_q.strike_velocity;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			found_q    <= 1'b0;
			free_any_q <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			for (int i = 0; i < svoice_pkg::VOICE_COUNT; i++) begin
				free_q[i]  <= 1'b1;
				note_q[i]  <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			done_q <= cmd.commit && emit;
			if (cmd.load) begin
				idx_q      <= '0;
				found_q    <= 1'b0;
				free_any_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + svoice_pkg::VIDX_W'(1);
				if (!found_q && !cur_free && note_q[idx_q] == req_q.note_number) begin
					found_q <= 1'b1;
				end
				if (cur_free) begin
					free_any_q <= 1'b1;
				end
			end
			if (cmd.commit && emit) begin
				if (is_off) begin
					free_q[pick] <= 1'b1;
				end else begin
					cnt_q         <= cnt_next;
					free_q[pick]  <= 1'b0;
					note_q[pick]  <= req_q.note_number;
					stamp_q[pick] <= cnt_next;
				end
			end
		end
	end

	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.commit))
		else $error("result strobe without a commit");

	a_cnt_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> ($past(cmd.commit) && $past(req_q.kind) == svoice_pkg::KIND_ON))
		else $error("trigger counter moved outside a note-on commit");

	a_release_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.action == svoice_pkg::ACT_RELEASE) |->
		(res_q.velocity_out == '0 && res_q.choice_source == svoice_pkg::SRC_SAME))
		else $error("release result carries velocity or source");

endmodule
`default_nettype wire
